// ----- src/bpr_pkg.sv -----
package bpr_pkg;

   localparam int ClassCount          = 20;
   localparam int CordicStagesDefault = 16;

   localparam int VecW = 34;   // vectoring x/y, signed
   localparam int AngW = 25;   // angle in 2^-20 rad, signed
   localparam int RotW = 40;   // rotation x/y, signed
   localparam int NumW = 32;   // rounded dividend
   localparam int DenW = 20;   // divisor, pixels * 256
   localparam int QuoW = 16;   // quotient bits before saturation
   localparam int RemW = DenW + QuoW;

   localparam logic [12:0] ImageWidthReset = 13'd640;
   localparam logic [19:0] FocalPxReset    = 20'd141898;
   localparam logic [11:0] MinBoxPxReset   = 12'd8;
   localparam logic [11:0] AspectTolReset  = 12'd512;
   localparam logic [15:0] MaxRangeReset   = 16'd12288;

   localparam logic signed [AngW-1:0] AngPi     = 25'sd3294199;
   localparam logic signed [AngW-1:0] AngHalfPi = 25'sd1647099;
   localparam logic signed [AngW-1:0] AngTwoPi  = 25'sd6588397;
   localparam logic [19:0]            CordicKinv = 20'd636751;

   typedef enum logic [2:0] {
      CSR_IMAGE_WIDTH = 3'd0,
      CSR_FOCAL_PX    = 3'd1,
      CSR_MIN_BOX_PX  = 3'd2,
      CSR_ASPECT_TOL  = 3'd3,
      CSR_MAX_RANGE   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [12:0] frame_w;
      logic [19:0] focal_px;
      logic [11:0] min_dim;
      logic [11:0] shape_tol;
      logic [15:0] max_range;
   } cfg_type;

   typedef struct packed {
      logic [7:0]         cls_code;
      logic [11:0]        box_left;
      logic [11:0]        box_width;
      logic [11:0]        box_height;
      logic signed [15:0] camera_yaw;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [10:0]        ref_h;
      logic signed [15:0] yaw;
   } trk_type;

   typedef struct packed {
      trk_type               trk;
      logic signed [VecW-1:0] vx;
      logic signed [VecW-1:0] vy;
      logic [NumW-1:0]       num;
      logic [DenW-1:0]       den;
      logic                  ovf;
   } scr_out_type;

   typedef struct packed {
      trk_type               trk;
      logic signed [AngW-1:0] ang;
      logic [NumW-1:0]       num;
      logic [DenW-1:0]       den;
      logic                  ovf;
   } vec_out_type;

   typedef struct packed {
      trk_type               trk;
      logic signed [AngW-1:0] ang;
      logic [QuoW-1:0]       quo;
      logic                  ovf;
   } div_out_type;

   typedef struct packed {
      logic               valid_res;
      logic [10:0]        ref_h;
      logic [15:0]        distance;
      logic signed [16:0] pos_x;
      logic signed [16:0] pos_z;
      logic [10:0]        pos_y;
   } res_type;

   function automatic logic [10:0] height_lut(input logic [7:0] cls);
      logic [10:0] v;
      v = 11'd0;
      if (int'(cls) < ClassCount) begin
         case (cls)
            8'd4:    v = 11'd256;
            8'd7:    v = 11'd307;
            8'd8:    v = 11'd870;
            8'd10:   v = 11'd768;
            8'd11:   v = 11'd512;
            8'd14:   v = 11'd1741;
            8'd15:   v = 11'd410;
            8'd17:   v = 11'd922;
            8'd19:   v = 11'd512;
            default: v = 11'd0;
         endcase
      end
      return v;
   endfunction

   function automatic logic [10:0] width_lut(input logic [7:0] cls);
      logic [10:0] v;
      v = 11'd0;
      if (int'(cls) < ClassCount) begin
         case (cls)
            8'd10:   v = 11'd1434;
            8'd17:   v = 11'd1946;
            8'd19:   v = 11'd563;
            default: v = 11'd0;
         endcase
      end
      return v;
   endfunction

   function automatic logic [19:0] atan_lut(input int i);
      logic [19:0] v;
      case (i)
         0:       v = 20'd823550;
         1:       v = 20'd486170;
         2:       v = 20'd256879;
         3:       v = 20'd130396;
         4:       v = 20'd65451;
         5:       v = 20'd32757;
         6:       v = 20'd16383;
         7:       v = 20'd8192;
         8:       v = 20'd4096;
         9:       v = 20'd2048;
         10:      v = 20'd1024;
         11:      v = 20'd512;
         12:      v = 20'd256;
         13:      v = 20'd128;
         14:      v = 20'd64;
         15:      v = 20'd32;
         16:      v = 20'd16;
         17:      v = 20'd8;
         18:      v = 20'd4;
         19:      v = 20'd2;
         20:      v = 20'd1;
         default: v = 20'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- src/bpr_screen.sv -----
module bpr_screen (
   input  logic                  clock,
   input  logic                  reset,
   input  bpr_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  bpr_pkg::req_type      in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bpr_pkg::scr_out_type  out_item
);

   typedef struct packed {
      logic               ok;
      logic [10:0]        rh;
      logic [10:0]        rw;
      logic [11:0]        bw;
      logic [11:0]        bh;
      logic [11:0]        dim;
      logic               use_w;
      logic               asp_en;
      logic signed [14:0] off;
      logic signed [15:0] yaw;
   } sa_type;

   typedef struct packed {
      logic               ok;
      logic [10:0]        rh;
      logic               asp_en;
      logic signed [14:0] off;
      logic signed [15:0] yaw;
      logic [22:0]        got;
      logic [22:0]        expv;
      logic [30:0]        num;
      logic [19:0]        den;
   } sb_type;

   typedef struct packed {
      logic               ok;
      logic [10:0]        rh;
      logic               asp_en;
      logic signed [14:0] off;
      logic signed [15:0] yaw;
      logic [34:0]        got_t;
      logic [34:0]        exp_t;
      logic [30:0]        got_s;
      logic [30:0]        exp_s;
      logic [31:0]        num;
      logic [19:0]        den;
   } sc_type;

   logic [3:0] valid_ff;
   logic [4:0] rdy;
   sa_type     sa_ff, sa_in;
   sb_type     sb_ff, sb_in;
   sc_type     sc_ff, sc_in;
   bpr_pkg::scr_out_type sd_ff, sd_in;

   assign rdy[4]    = out_ready;
   assign rdy[3]    = !valid_ff[3] || rdy[4];
   assign rdy[2]    = !valid_ff[2] || rdy[3];
   assign rdy[1]    = !valid_ff[1] || rdy[2];
   assign rdy[0]    = !valid_ff[0] || rdy[1];
   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[3];
   assign out_item  = sd_ff;

   // lookup, clip and size screening
   always_comb begin
      logic clipped;
      logic [13:0] right;
      sa_in.rh  = bpr_pkg::height_lut(in_item.cls_code);
      sa_in.rw  = bpr_pkg::width_lut(in_item.cls_code);
      right     = 14'(in_item.box_left) + 14'(in_item.box_width) + 14'd2;
      clipped   = (in_item.box_left <= 12'd1) || (right >= 14'(cfg.frame_w));
      sa_in.use_w  = (sa_in.rw != 11'd0) && (in_item.box_width != 12'd0) && !clipped;
      sa_in.asp_en = (sa_in.rw != 11'd0) && !clipped;
      sa_in.dim    = sa_in.use_w ? in_item.box_width : in_item.box_height;
      sa_in.ok     = (sa_in.rh != 11'd0) && (in_item.box_height != 12'd0)
                     && (sa_in.dim >= cfg.min_dim);
      sa_in.bw     = in_item.box_width;
      sa_in.bh     = in_item.box_height;
      sa_in.off    = signed'(15'({in_item.box_left, 1'b0}) + 15'(in_item.box_width)
                             - 15'(cfg.frame_w));
      sa_in.yaw    = in_item.camera_yaw;
   end

   // aspect and range products
   always_comb begin
      sb_in.ok     = sa_ff.ok;
      sb_in.rh     = sa_ff.rh;
      sb_in.asp_en = sa_ff.asp_en;
      sb_in.off    = sa_ff.off;
      sb_in.yaw    = sa_ff.yaw;
      sb_in.got    = 23'(sa_ff.bw) * 23'(sa_ff.rh);
      sb_in.expv   = 23'(sa_ff.bh) * 23'(sa_ff.rw);
      sb_in.num    = 31'(sa_ff.use_w ? sa_ff.rw : sa_ff.rh) * 31'(cfg.focal_px);
      sb_in.den    = {sa_ff.dim, 8'd0};
   end

   // scale by tolerance, round the dividend
   always_comb begin
      sc_in.ok     = sb_ff.ok;
      sc_in.rh     = sb_ff.rh;
      sc_in.asp_en = sb_ff.asp_en;
      sc_in.off    = sb_ff.off;
      sc_in.yaw    = sb_ff.yaw;
      sc_in.got_t  = 35'(sb_ff.got) * 35'(cfg.shape_tol);
      sc_in.exp_t  = 35'(sb_ff.expv) * 35'(cfg.shape_tol);
      sc_in.got_s  = {sb_ff.got, 8'd0};
      sc_in.exp_s  = {sb_ff.expv, 8'd0};
      sc_in.num    = 32'(sb_ff.num) + 32'(sb_ff.den >> 1);
      sc_in.den    = sb_ff.den;
   end

   // aspect verdict, overflow test, vectoring operands
   always_comb begin
      logic asp_bad;
      asp_bad = sc_ff.asp_en && ((35'(sc_ff.got_s) > sc_ff.exp_t)
                                 || (sc_ff.got_t < 35'(sc_ff.exp_s)));
      sd_in.trk.ok    = sc_ff.ok && !asp_bad;
      sd_in.trk.ref_h = sc_ff.rh;
      sd_in.trk.yaw   = sc_ff.yaw;
      sd_in.num       = sc_ff.num;
      sd_in.den       = sc_ff.den;
      sd_in.ovf       = 36'(sc_ff.num) >= {sc_ff.den, 16'd0};
      sd_in.vx        = signed'(bpr_pkg::VecW'({cfg.focal_px, 8'd0}));
      sd_in.vy        = bpr_pkg::VecW'(sc_ff.off) <<< 15;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         if (rdy[1]) valid_ff[1] <= valid_ff[0];
         if (rdy[2]) valid_ff[2] <= valid_ff[1];
         if (rdy[3]) valid_ff[3] <= valid_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid)    sa_ff <= sa_in;
      if (rdy[1] && valid_ff[0]) sb_ff <= sb_in;
      if (rdy[2] && valid_ff[1]) sc_ff <= sc_in;
      if (rdy[3] && valid_ff[2]) sd_ff <= sd_in;
   end

endmodule

// ----- src/bpr_vec.sv -----
module bpr_vec #(
   parameter int Stages = bpr_pkg::CordicStagesDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  bpr_pkg::scr_out_type  in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bpr_pkg::vec_out_type  out_item
);

   typedef struct packed {
      bpr_pkg::trk_type                trk;
      logic signed [bpr_pkg::VecW-1:0] x;
      logic signed [bpr_pkg::VecW-1:0] y;
      logic signed [bpr_pkg::AngW-1:0] ang;
      logic [bpr_pkg::NumW-1:0]        num;
      logic [bpr_pkg::DenW-1:0]        den;
      logic                            ovf;
   } vst_type;

   logic [Stages-1:0] valid_ff;
   logic [Stages:0]   rdy;
   vst_type           st_ff [Stages];
   vst_type           st_in [Stages];
   vst_type           init;

   assign init.trk = in_item.trk;
   assign init.x   = in_item.vx;
   assign init.y   = in_item.vy;
   assign init.ang = '0;
   assign init.num = in_item.num;
   assign init.den = in_item.den;
   assign init.ovf = in_item.ovf;

   assign rdy[Stages] = out_ready;
   assign in_ready    = rdy[0];
   assign out_valid   = valid_ff[Stages-1];

   assign out_item.trk = st_ff[Stages-1].trk;
   assign out_item.ang = st_ff[Stages-1].ang;
   assign out_item.num = st_ff[Stages-1].num;
   assign out_item.den = st_ff[Stages-1].den;
   assign out_item.ovf = st_ff[Stages-1].ovf;

   for (genvar k = 0; k < Stages; k++) begin : g_it
      localparam logic signed [bpr_pkg::AngW-1:0] AtanK =
         signed'(bpr_pkg::AngW'(bpr_pkg::atan_lut(k)));
      vst_type src;
      logic    src_valid;

      if (k == 0) begin : g_first
         assign src       = init;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src       = st_ff[k-1];
         assign src_valid = valid_ff[k-1];
      end

      assign rdy[k] = !valid_ff[k] || rdy[k+1];

      // rotate toward the x axis
      always_comb begin
         st_in[k] = src;
         if (src.y > 0) begin
            st_in[k].x   = src.x + (src.y >>> k);
            st_in[k].y   = src.y - (src.x >>> k);
            st_in[k].ang = src.ang + AtanK;
         end else begin
            st_in[k].x   = src.x - (src.y >>> k);
            st_in[k].y   = src.y + (src.x >>> k);
            st_in[k].ang = src.ang - AtanK;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && src_valid) st_ff[k] <= st_in[k];
      end
   end

endmodule

// ----- src/bpr_div.sv -----
module bpr_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  bpr_pkg::vec_out_type  in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bpr_pkg::div_out_type  out_item
);

   localparam int Stages = bpr_pkg::QuoW;

   typedef struct packed {
      bpr_pkg::trk_type                trk;
      logic signed [bpr_pkg::AngW-1:0] ang;
      logic [bpr_pkg::RemW-1:0]        rem;
      logic [bpr_pkg::DenW-1:0]        den;
      logic [bpr_pkg::QuoW-1:0]        quo;
      logic                            ovf;
   } dst_type;

   logic [Stages-1:0] valid_ff;
   logic [Stages:0]   rdy;
   dst_type           st_ff [Stages];
   dst_type           st_in [Stages];
   dst_type           init;

   assign init.trk = in_item.trk;
   assign init.ang = in_item.ang;
   assign init.rem = bpr_pkg::RemW'(in_item.num);
   assign init.den = in_item.den;
   assign init.quo = '0;
   assign init.ovf = in_item.ovf;

   assign rdy[Stages] = out_ready;
   assign in_ready    = rdy[0];
   assign out_valid   = valid_ff[Stages-1];

   assign out_item.trk = st_ff[Stages-1].trk;
   assign out_item.ang = st_ff[Stages-1].ang;
   assign out_item.quo = st_ff[Stages-1].quo;
   assign out_item.ovf = st_ff[Stages-1].ovf;

   for (genvar k = 0; k < Stages; k++) begin : g_bit
      localparam int Sh = bpr_pkg::QuoW - 1 - k;
      dst_type                  src;
      logic                     src_valid;
      logic [bpr_pkg::RemW-1:0] dsh;

      if (k == 0) begin : g_first
         assign src       = init;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src       = st_ff[k-1];
         assign src_valid = valid_ff[k-1];
      end

      assign rdy[k] = !valid_ff[k] || rdy[k+1];
      assign dsh    = bpr_pkg::RemW'(src.den) << Sh;

      // one restoring step, most significant quotient bit first
      always_comb begin
         st_in[k] = src;
         if (src.rem >= dsh) begin
            st_in[k].rem     = src.rem - dsh;
            st_in[k].quo[Sh] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && src_valid) st_ff[k] <= st_in[k];
      end
   end

endmodule

// ----- src/bpr_rot.sv -----
module bpr_rot #(
   parameter int Stages = bpr_pkg::CordicStagesDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bpr_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  bpr_pkg::div_out_type  in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bpr_pkg::res_type      out_item
);

   localparam int Total = Stages + 4;
   localparam int Last  = Total - 1;

   typedef struct packed {
      logic                            ok;
      logic [10:0]                     rh;
      logic [15:0]                     range_m;
      logic signed [bpr_pkg::AngW-1:0] a;
      logic signed [bpr_pkg::RotW-1:0] cx;
      logic signed [bpr_pkg::RotW-1:0] cy;
      logic                            flip;
   } rst_type;

   logic [Total-1:0] valid_ff;
   logic [Total:0]   rdy;
   rst_type          p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   rst_type          st_ff [Stages];
   rst_type          st_in [Stages];
   bpr_pkg::res_type res_ff, res_in;

   function automatic logic signed [16:0] round_sat(input logic signed [bpr_pkg::RotW-1:0] v);
      logic signed [bpr_pkg::RotW-1:0] t;
      logic signed [16:0]              r;
      t = (v + bpr_pkg::RotW'(1 << 19)) >>> 20;
      if (t > bpr_pkg::RotW'(65535)) begin
         r = 17'sd65535;
      end else if (t < -bpr_pkg::RotW'(65536)) begin
         r = -17'sd65536;
      end else begin
         r = t[16:0];
      end
      return r;
   endfunction

   assign rdy[Total] = out_ready;
   for (genvar j = 0; j < Total; j++) begin : g_rdy
      assign rdy[j] = !valid_ff[j] || rdy[j+1];
   end
   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[Last];
   assign out_item  = res_ff;

   // saturate distance, range gate, world angle wrap
   always_comb begin
      logic signed [bpr_pkg::AngW-1:0] a0;
      logic signed [bpr_pkg::AngW-1:0] a1;
      p0_in         = '0;
      p0_in.range_m = in_item.ovf ? 16'hFFFF : in_item.quo;
      p0_in.ok      = in_item.trk.ok && (p0_in.range_m <= cfg.max_range);
      p0_in.rh      = in_item.trk.ref_h;
      a0 = (bpr_pkg::AngW'(in_item.trk.yaw) <<< 7) + in_item.ang;
      a1 = (a0 > bpr_pkg::AngPi) ? a0 - bpr_pkg::AngTwoPi : a0;
      p0_in.a = (a1 < -bpr_pkg::AngPi) ? a1 + bpr_pkg::AngTwoPi : a1;
   end

   // gain-compensated start vector, fold the angle into the right half plane
   always_comb begin
      p1_in    = p0_ff;
      p1_in.cx = signed'(bpr_pkg::RotW'(36'(p0_ff.range_m) * 36'(bpr_pkg::CordicKinv)));
      p1_in.cy = '0;
      p1_in.flip = 1'b0;
      if (p0_ff.a > bpr_pkg::AngHalfPi) begin
         p1_in.a    = p0_ff.a - bpr_pkg::AngPi;
         p1_in.flip = 1'b1;
      end else if (p0_ff.a < -bpr_pkg::AngHalfPi) begin
         p1_in.a    = p0_ff.a + bpr_pkg::AngPi;
         p1_in.flip = 1'b1;
      end
   end

   always_comb begin
      p2_in = p1_ff;
      if (p1_ff.flip) p2_in.cx = -p1_ff.cx;
   end

   for (genvar k = 0; k < Stages; k++) begin : g_it
      localparam logic signed [bpr_pkg::AngW-1:0] AtanK =
         signed'(bpr_pkg::AngW'(bpr_pkg::atan_lut(k)));
      rst_type src;

      if (k == 0) begin : g_first
         assign src = p2_ff;
      end else begin : g_next
         assign src = st_ff[k-1];
      end

      // drive the residual angle toward zero
      always_comb begin
         st_in[k] = src;
         if (src.a >= 0) begin
            st_in[k].cx = src.cx - (src.cy >>> k);
            st_in[k].cy = src.cy + (src.cx >>> k);
            st_in[k].a  = src.a - AtanK;
         end else begin
            st_in[k].cx = src.cx + (src.cy >>> k);
            st_in[k].cy = src.cy - (src.cx >>> k);
            st_in[k].a  = src.a + AtanK;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k+3] && valid_ff[k+2]) st_ff[k] <= st_in[k];
      end
   end

   always_comb begin
      res_in.valid_res = st_ff[Stages-1].ok;
      res_in.ref_h     = st_ff[Stages-1].rh;
      res_in.distance  = st_ff[Stages-1].ok ? st_ff[Stages-1].range_m : 16'd0;
      res_in.pos_x     = st_ff[Stages-1].ok ? round_sat(st_ff[Stages-1].cy) : 17'sd0;
      res_in.pos_z     = st_ff[Stages-1].ok ? round_sat(st_ff[Stages-1].cx) : 17'sd0;
      res_in.pos_y     = st_ff[Stages-1].ok ? (st_ff[Stages-1].rh >> 1) : 11'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         for (int j = 1; j < Total; j++) begin
            if (rdy[j]) valid_ff[j] <= valid_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid)          p0_ff  <= p0_in;
      if (rdy[1] && valid_ff[0])       p1_ff  <= p1_in;
      if (rdy[2] && valid_ff[1])       p2_ff  <= p2_in;
      if (rdy[Last] && valid_ff[Last-1]) res_ff <= res_in;
   end

endmodule

// ----- src/bbox_pinhole_range_and_place.sv -----
// Ranges and places one detected object per item with a pinhole camera model:
// the class's known height or width, the focal length and the box size in
// pixels give the distance, a vectoring CORDIC gives the bearing of the box
// centre and a rotation CORDIC turns distance and world yaw into x and z.
// Unknown classes, empty or undersized boxes, boxes of the wrong aspect and
// targets beyond max_range come back with valid_res low and zero position.
// The block takes one item every clock cycle unless a stall on the result
// side backs up to the input. An item passes through four screening stages,
// CORDIC_STAGES vectoring stages, sixteen restoring divider stages, and
// CORDIC_STAGES + 4 rotation and output stages. Every stage has
// its own valid bit and moves up when the stage after it is free, so stalls
// on the result side fill bubbles before they hold back the input. Write the
// CSR registers only while no item is in flight.
module bbox_pinhole_range_and_place #(
   parameter int CORDIC_STAGES = bpr_pkg::CordicStagesDefault
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // cls_code[7:0], box_left[19:8], box_width[31:20], box_height[43:32],
   // camera_yaw[59:44], zero pad[63:60]
   input  logic [63:0] req_tdata,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // ref_h[10:0], distance[26:11], pos_x[43:27], pos_z[60:44],
   // pos_y[71:61]
   output logic [71:0] rsp_tdata,
   // valid_res[0]
   output logic        rsp_tuser,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_data
);

   bpr_pkg::cfg_type     cfg_ff, cfg_in;
   bpr_pkg::req_type     req_item;
   bpr_pkg::scr_out_type scr_item;
   bpr_pkg::vec_out_type vec_item;
   bpr_pkg::div_out_type div_item;
   bpr_pkg::res_type     res_item;
   logic scr_valid, scr_ready, vec_valid, vec_ready, div_valid, div_ready;

   // Always take CSR writes; unknown indexes drop.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            bpr_pkg::CSR_IMAGE_WIDTH: cfg_in.frame_w   = csr_data[12:0];
            bpr_pkg::CSR_FOCAL_PX:    cfg_in.focal_px  = csr_data;
            bpr_pkg::CSR_MIN_BOX_PX:  cfg_in.min_dim   = csr_data[11:0];
            bpr_pkg::CSR_ASPECT_TOL:  cfg_in.shape_tol = csr_data[11:0];
            bpr_pkg::CSR_MAX_RANGE:   cfg_in.max_range = csr_data[15:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_w   <= bpr_pkg::ImageWidthReset;
         cfg_ff.focal_px  <= bpr_pkg::FocalPxReset;
         cfg_ff.min_dim   <= bpr_pkg::MinBoxPxReset;
         cfg_ff.shape_tol <= bpr_pkg::AspectTolReset;
         cfg_ff.max_range <= bpr_pkg::MaxRangeReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Unpack the request item.
   assign req_item.cls_code   = req_tdata[7:0];
   assign req_item.box_left   = req_tdata[19:8];
   assign req_item.box_width  = req_tdata[31:20];
   assign req_item.box_height = req_tdata[43:32];
   assign req_item.camera_yaw = signed'(req_tdata[59:44]);

   // Lookup, clip test, aspect check and divider operands.
   bpr_screen u_screen (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (scr_valid),
      .out_ready (scr_ready),
      .out_item  (scr_item)
   );

   // Bearing of the box centre.
   bpr_vec #(.Stages(CORDIC_STAGES)) u_vec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scr_valid),
      .in_ready  (scr_ready),
      .in_item   (scr_item),
      .out_valid (vec_valid),
      .out_ready (vec_ready),
      .out_item  (vec_item)
   );

   // Distance quotient, one bit per stage.
   bpr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vec_valid),
      .in_ready  (vec_ready),
      .in_item   (vec_item),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_item  (div_item)
   );

   // Range gate, world placement and the result register.
   bpr_rot #(.Stages(CORDIC_STAGES)) u_rot (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_item   (div_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (res_item)
   );

   assign rsp_tdata = {res_item.pos_y, res_item.pos_z, res_item.pos_x,
                       res_item.distance, res_item.ref_h};
   assign rsp_tuser = res_item.valid_res;

endmodule

// ----- tb/sv/bbox_place_checker.sv -----
module bbox_place_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_data,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [12:0] cfg_width;
   logic [19:0] cfg_focal;
   logic [11:0] cfg_min_box;
   logic [11:0] cfg_tol;
   logic [15:0] cfg_max_range;

   bpr_pkg::res_type placement_q[$];

   function automatic longint floor_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -(((-v) - 1) >>> s) - 1;
   endfunction

   function automatic logic signed [16:0] clamp17(longint v);
      if (v > 65535) v = 65535;
      if (v < -65536) v = -65536;
      return v[16:0];
   endfunction

   function automatic bpr_pkg::res_type place_object(bpr_pkg::req_type d);
      bpr_pkg::res_type r;
      longint bl, bw, bh, yaw, rh, rw, num, den, est, vx, vy, ang, a, cx, cy, sx, sy;
      longint got, want;
      bit clipped, by_width;
      r = '0;
      bl = d.box_left; bw = d.box_width; bh = d.box_height; yaw = d.camera_yaw;
      rh = bpr_pkg::height_lut(d.cls_code);
      rw = bpr_pkg::width_lut(d.cls_code);
      r.ref_h = rh[10:0];
      if (rh == 0 || bh == 0) return r;
      clipped = (bl <= 1) || (bl + bw >= longint'(cfg_width) - 2);
      by_width = rw > 0 && bw > 0 && !clipped;
      if ((by_width ? bw : bh) < longint'(cfg_min_box)) return r;
      if (rw > 0 && !clipped) begin
         got = bw * rh; want = bh * rw;
         if (got * 256 > longint'(cfg_tol) * want || got * longint'(cfg_tol) < 256 * want)
            return r;
      end
      if (by_width) begin
         num = rw * cfg_focal; den = bw * 256;
      end else begin
         num = rh * cfg_focal; den = bh * 256;
      end
      est = (num + den / 2) / den;
      if (est > 65535) est = 65535;
      if (est > longint'(cfg_max_range)) return r;
      // bearing of the box centre
      vx = longint'(cfg_focal) * 256;
      vy = (2 * bl + bw - longint'(cfg_width)) * 32768;
      ang = 0;
      for (int i = 0; i < bpr_pkg::CordicStagesDefault; i++) begin
         sx = floor_shift(vx, i); sy = floor_shift(vy, i);
         if (vy > 0) begin
            vx += sy; vy -= sx; ang += bpr_pkg::atan_lut(i);
         end else begin
            vx -= sy; vy += sx; ang -= bpr_pkg::atan_lut(i);
         end
      end
      a = yaw * 128 + ang;
      if (a > bpr_pkg::AngPi) a -= bpr_pkg::AngTwoPi;
      if (a < -bpr_pkg::AngPi) a += bpr_pkg::AngTwoPi;
      cx = est * longint'(bpr_pkg::CordicKinv);
      cy = 0;
      if (a > bpr_pkg::AngHalfPi) begin
         a -= bpr_pkg::AngPi; cx = -cx;
      end else if (a < -bpr_pkg::AngHalfPi) begin
         a += bpr_pkg::AngPi; cx = -cx;
      end
      for (int i = 0; i < bpr_pkg::CordicStagesDefault; i++) begin
         sx = floor_shift(cx, i); sy = floor_shift(cy, i);
         if (a >= 0) begin
            cx -= sy; cy += sx; a -= bpr_pkg::atan_lut(i);
         end else begin
            cx += sy; cy -= sx; a += bpr_pkg::atan_lut(i);
         end
      end
      r.valid_res = 1'b1;
      r.distance = est[15:0];
      r.pos_x = clamp17(floor_shift(cy + (1 << 19), 20));
      r.pos_z = clamp17(floor_shift(cx + (1 << 19), 20));
      r.pos_y = rh[10:0] >> 1;
      return r;
   endfunction

   always @(posedge clock) begin
      bpr_pkg::res_type want, got;
      if (reset) begin
         cfg_width <= bpr_pkg::ImageWidthReset;
         cfg_focal <= bpr_pkg::FocalPxReset;
         cfg_min_box <= bpr_pkg::MinBoxPxReset;
         cfg_tol <= bpr_pkg::AspectTolReset;
         cfg_max_range <= bpr_pkg::MaxRangeReset;
         placement_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (bpr_pkg::csr_index_type'(csr_index))
               bpr_pkg::CSR_IMAGE_WIDTH: cfg_width <= csr_data[12:0];
               bpr_pkg::CSR_FOCAL_PX:    cfg_focal <= csr_data;
               bpr_pkg::CSR_MIN_BOX_PX:  cfg_min_box <= csr_data[11:0];
               bpr_pkg::CSR_ASPECT_TOL:  cfg_tol <= csr_data[11:0];
               bpr_pkg::CSR_MAX_RANGE:   cfg_max_range <= csr_data[15:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.valid_res = rsp_tuser;
            got.ref_h = rsp_tdata[10:0];
            got.distance = rsp_tdata[26:11];
            got.pos_x = rsp_tdata[43:27];
            got.pos_z = rsp_tdata[60:44];
            got.pos_y = rsp_tdata[71:61];
            if (placement_q.size() == 0) begin
               $display("%0t: unexpected result %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = placement_q.pop_front();
               if (want !== got) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            placement_q.push_back(place_object(bpr_pkg::req_type'({req_tdata[7:0],
               req_tdata[19:8], req_tdata[31:20], req_tdata[43:32], req_tdata[59:44]})));
         pending <= placement_q.size();
      end
   end
endmodule

// ----- tb/sv/tb_bbox_pinhole_range_and_place.sv -----
module tb_bbox_pinhole_range_and_place;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Latency = 24 + 2 * bpr_pkg::CordicStagesDefault;
   localparam int CycleLimit = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [19:0] csr_data = '0;
   int          fail_count;
   int          pending;
   int          cycles = 0;
   bit          calm = 1'b0;

   always #5 clock = ~clock;

   bbox_pinhole_range_and_place dut (.*);

   bbox_place_checker chk (.*);

   // Stop a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: stall in short random bursts until the calm final stretch.
   initial begin
      int hold;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            hold = $urandom_range(1, 5);
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   task automatic write_reg(bpr_pkg::csr_index_type idx, logic [19:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every result is back, then let the pipe drain.
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (Latency + 4) @(negedge clock);
   endtask

   task automatic send_detection(logic [7:0] cls, logic [11:0] bl, logic [11:0] bw,
                                 logic [11:0] bh, logic [15:0] yaw);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, yaw, bh, bw, bl, cls};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_detection();
      logic [7:0] cls;
      logic [11:0] bl, bw, bh;
      logic [15:0] yaw;
      int pick;
      pick = $urandom_range(0, 9);
      // most items are plausible known-class boxes; the rest are noise
      if (pick < 7) begin
         case ($urandom_range(0, 2))
            0: cls = 8'd10;
            1: cls = 8'd17;
            default: cls = 8'd19;
         endcase
         if ($urandom_range(0, 2) == 0) cls = 8'd4 + 8'($urandom_range(0, 15));
         bh = 12'($urandom_range(8, 300));
         bw = 12'((bh * bpr_pkg::width_lut(cls) + $urandom_range(0, 200) - 100)
                   / (bpr_pkg::height_lut(cls) == 0 ? 1 : bpr_pkg::height_lut(cls)));
         bl = 12'($urandom_range(0, 640));
      end else begin
         cls = 8'($urandom);
         bl = 12'($urandom); bw = 12'($urandom); bh = 12'($urandom);
      end
      yaw = 16'($signed($urandom_range(0, 51472)) - 25736);
      send_detection(cls, bl, bw, bh, yaw);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes, unknown classes, zero height, clipped edges,
      // width ranging, aspect reject, far target.
      send_detection(8'd0, 12'd100, 12'd50, 12'd50, 16'd0);
      send_detection(8'd255, 12'hFFF, 12'hFFF, 12'hFFF, 16'h8000);
      send_detection(8'd20, 12'd100, 12'd50, 12'd50, 16'd0);
      send_detection(8'd8, 12'd100, 12'd40, 12'd0, 16'd0);
      send_detection(8'd8, 12'd0, 12'd40, 12'd100, 16'sd25736);
      send_detection(8'd8, 12'd1, 12'd40, 12'd100, -16'sd25736);
      send_detection(8'd8, 12'd600, 12'd38, 12'd100, 16'd0);
      send_detection(8'd17, 12'd200, 12'd100, 12'd47, 16'd1000);
      send_detection(8'd17, 12'd200, 12'd100, 12'd20, 16'd0);
      send_detection(8'd17, 12'd200, 12'd100, 12'd200, 16'd0);
      send_detection(8'd10, 12'd300, 12'd4, 12'd2, 16'd0);
      send_detection(8'd19, 12'd2, 12'd0, 12'd60, 16'd0);
      send_detection(8'd14, 12'd320, 12'd10, 12'd9, 16'd0);
      send_detection(8'd4, 12'd10, 12'd5, 12'd4095, -16'sd20000);
      send_detection(8'd7, 12'd630, 12'd2, 12'd30, 16'sd20000);
      req_tvalid <= 1'b0;
      drain();

      // Register sweep, extremes first.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(bpr_pkg::CSR_IMAGE_WIDTH, 20'd4096);
               write_reg(bpr_pkg::CSR_FOCAL_PX, 20'hFFFFF);
               write_reg(bpr_pkg::CSR_MIN_BOX_PX, 20'd0);
               write_reg(bpr_pkg::CSR_ASPECT_TOL, 20'd4095);
               write_reg(bpr_pkg::CSR_MAX_RANGE, 20'd65535);
            end
            1: begin
               write_reg(bpr_pkg::CSR_IMAGE_WIDTH, 20'd1);
               write_reg(bpr_pkg::CSR_FOCAL_PX, 20'd1);
               write_reg(bpr_pkg::CSR_MIN_BOX_PX, 20'd4095);
               write_reg(bpr_pkg::CSR_ASPECT_TOL, 20'd256);
               write_reg(bpr_pkg::CSR_MAX_RANGE, 20'd0);
            end
            2: begin
               write_reg(bpr_pkg::CSR_IMAGE_WIDTH, 20'd640);
               write_reg(bpr_pkg::CSR_FOCAL_PX, 20'd141898);
               write_reg(bpr_pkg::CSR_MIN_BOX_PX, 20'd8);
               write_reg(bpr_pkg::CSR_ASPECT_TOL, 20'd0);
               write_reg(bpr_pkg::CSR_MAX_RANGE, 20'd12288);
            end
            default: begin
               write_reg(bpr_pkg::CSR_IMAGE_WIDTH, 20'($urandom_range(320, 1920)));
               write_reg(bpr_pkg::CSR_FOCAL_PX, 20'($urandom_range(20000, 1048575)));
               write_reg(bpr_pkg::CSR_MIN_BOX_PX, 20'($urandom_range(0, 16)));
               write_reg(bpr_pkg::CSR_ASPECT_TOL, 20'($urandom_range(300, 4095)));
               write_reg(bpr_pkg::CSR_MAX_RANGE, 20'($urandom_range(4096, 65535)));
            end
         endcase
         if (phase == 5) calm = 1'b1;
         for (int n = 0; n < 255; n++) begin
            random_detection();
            // hold off once until the pipe is empty
            if (phase == 3 && n == 100) begin
               req_tvalid <= 1'b0;
               while (pending != 0) @(negedge clock);
            end
         end
         req_tvalid <= 1'b0;
         drain();
      end

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// ----- filelist.f -----
src/bpr_pkg.sv
src/bpr_screen.sv
src/bpr_vec.sv
src/bpr_div.sv
src/bpr_rot.sv
src/bbox_pinhole_range_and_place.sv
tb/sv/bbox_place_checker.sv
tb/sv/tb_bbox_pinhole_range_and_place.sv
